FILE: sv/twoi_pkg.sv
// Shared types and constants of the three-wheel odometry integrator.
// No dependencies.
`default_nettype none
package twoi_pkg;

   localparam int CORDIC_STEPS_DEF   = 16;
   localparam int POSITION_WIDTH_DEF = 48;

   localparam int GAIN_W     = 24;
   localparam int SPEED_W    = 16;
   localparam int HEAD_W     = 32;
   localparam int DIV_BITS   = 30;
   localparam int DIVISOR    = 125;
   localparam int CORDIC_W   = 26;
   localparam int K_BITS     = 32;
   localparam int CNT_W      = 5;
   localparam int ABS_SUM_W  = 17;
   localparam int HEAD_FRAC  = 22;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd239523;
   localparam logic [K_BITS-1:0] CORDIC_K   = 32'h9B74EDA8;
   localparam logic signed [HEAD_W-1:0] DEG_90  = 32'sd377487360;
   localparam logic signed [HEAD_W+1:0] DEG_180 = 34'sd754974720;
   localparam logic signed [HEAD_W+1:0] DEG_360 = 34'sd1509949440;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_PREP,
      ST_ROT,
      ST_MAG,
      ST_SCALE,
      ST_ACC,
      ST_OUT
   } state_type;

   function automatic logic [HEAD_W-1:0] atan_q22(input logic [CNT_W-1:0] idx);
      logic [HEAD_W-1:0] v;
      case (idx)
         5'd0:  v = 32'd188743680;
         5'd1:  v = 32'd111421900;
         5'd2:  v = 32'd58872272;
         5'd3:  v = 32'd29884485;
         5'd4:  v = 32'd15000234;
         5'd5:  v = 32'd7507429;
         5'd6:  v = 32'd3754631;
         5'd7:  v = 32'd1877430;
         5'd8:  v = 32'd938729;
         5'd9:  v = 32'd469366;
         5'd10: v = 32'd234683;
         5'd11: v = 32'd117342;
         5'd12: v = 32'd58671;
         5'd13: v = 32'd29335;
         5'd14: v = 32'd14668;
         5'd15: v = 32'd7334;
         5'd16: v = 32'd3667;
         5'd17: v = 32'd1833;
         5'd18: v = 32'd917;
         5'd19: v = 32'd458;
         5'd20: v = 32'd229;
         5'd21: v = 32'd115;
         5'd22: v = 32'd57;
         5'd23: v = 32'd29;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

FILE: sv/twoi_div125.sv
// Bit-serial restoring divider by 125, one quotient bit per cycle while step is asserted.
// Depends on twoi_pkg.
`default_nettype none
module twoi_div125
   import twoi_pkg::*;
(
   input  wire                 clock,
   input  wire                 load,
   input  wire                 step,
   input  wire [DIV_BITS-1:0]  numer,
   output logic [DIV_BITS-1:0] quot
);

   logic [DIV_BITS-1:0] shift_ff, shift_in;
   logic [6:0]          rem_ff, rem_in;
   logic [7:0]          rem2;
   logic                ge;

   always_comb begin
      rem2     = {rem_ff, shift_ff[DIV_BITS-1]};
      ge       = rem2 >= 8'(DIVISOR);
      rem_in   = rem_ff;
      shift_in = shift_ff;
      if (load) begin
         rem_in   = '0;
         shift_in = numer;
      end else if (step) begin
         rem_in   = ge ? 7'(rem2 - 8'(DIVISOR)) : rem2[6:0];
         shift_in = {shift_ff[DIV_BITS-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
   end

   assign quot = shift_ff;

endmodule
`default_nettype wire

FILE: sv/three_wheel_odometry_integrator.sv
// Three-wheel odometry integrator: serial divide, CORDIC rotation, serial
// gain multiply, position and heading accumulation. Depends on twoi_pkg, twoi_div125.
// From request transfer to response an item runs through DIV, PREP, ROT, MAG, SCALE, ACC and OUT,
// with the 30-step divider, CORDIC_STEPS rotation steps and the 32-step serial K multiply.
// One item at a time: a new request is taken only in IDLE, and OUT waits while the response stalls.
// Synchronous reset clears accumulators, heading, gain to its default and control.
`default_nettype none
module three_wheel_odometry_integrator
   import twoi_pkg::*;
#(
   parameter int CORDIC_STEPS   = CORDIC_STEPS_DEF,
   parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_ready,
   input  wire signed [SPEED_W-1:0]  req_wheel_left_speed,
   input  wire signed [SPEED_W-1:0]  req_wheel_rear_speed,
   input  wire signed [SPEED_W-1:0]  req_wheel_right_speed,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output logic signed [15:0]        rsp_pos_x_mm,
   output logic signed [15:0]        rsp_pos_y_mm,
   output logic signed [8:0]         rsp_heading_deg,
   input  wire                       csr_valid,
   output logic                      csr_ready,
   input  wire [GAIN_W-1:0]          csr_data
);

   localparam int PW = POSITION_WIDTH;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [GAIN_W-1:0] gain_ff;
   logic signed [PW-1:0] x_acc_ff, y_acc_ff;
   logic signed [HEAD_W-1:0] head_ff;
   logic dx_neg_ff, dy_neg_ff, sum_pos_ff;
   logic [GAIN_W:0] hm_acc_ff;
   logic [ABS_SUM_W-1:0] hm_low_ff;
   logic signed [CORDIC_W-1:0] cx_ff, cy_ff;
   logic signed [HEAD_W-1:0] ang_ff;
   logic [CORDIC_W-1:0] mx_ff, my_ff, kx_ff, ky_ff;
   logic kx_neg_ff, ky_neg_ff;
   logic rsp_valid_ff;
   logic signed [15:0] rsp_x_ff, rsp_y_ff;
   logic signed [8:0] rsp_h_ff;

   // request decode
   logic signed [ABS_SUM_W-1:0] sum, diff;
   logic signed [ABS_SUM_W:0]   along;
   logic [ABS_SUM_W-1:0] abs_sum, abs_diff;
   logic [ABS_SUM_W:0]   abs_along;
   logic [DIV_BITS-1:0] numer_x, numer_y, quot_x, quot_y;
   logic req_xfer, div_load, div_step;

   assign req_ready = state_ff == ST_IDLE;
   assign req_xfer  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      sum       = ABS_SUM_W'(req_wheel_left_speed) + ABS_SUM_W'(req_wheel_right_speed);
      diff      = ABS_SUM_W'(req_wheel_left_speed) - ABS_SUM_W'(req_wheel_right_speed);
      along     = (ABS_SUM_W+1)'(req_wheel_rear_speed) + (ABS_SUM_W+1)'(req_wheel_rear_speed)
                  + (ABS_SUM_W+1)'(sum);
      abs_sum   = sum[ABS_SUM_W-1] ? ABS_SUM_W'(-sum) : ABS_SUM_W'(sum);
      abs_along = along[ABS_SUM_W] ? (ABS_SUM_W+1)'(-along) : (ABS_SUM_W+1)'(along);
      abs_diff  = diff[ABS_SUM_W-1] ? ABS_SUM_W'(-diff) : ABS_SUM_W'(diff);
      numer_x   = {abs_along, 12'd0};
      numer_y   = {1'b0, abs_diff, 12'd0};
   end

   assign div_load = req_xfer;
   assign div_step = state_ff == ST_DIV;

   twoi_div125 u_div_x (
      .clock(clock), .load(div_load), .step(div_step), .numer(numer_x), .quot(quot_x)
   );
   twoi_div125 u_div_y (
      .clock(clock), .load(div_load), .step(div_step), .numer(numer_y), .quot(quot_y)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_valid) state_in = ST_DIV;
         end
         ST_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_BITS - 1)) state_in = ST_PREP;
         end
         ST_PREP: begin
            cnt_in   = '0;
            state_in = ST_ROT;
         end
         ST_ROT: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(CORDIC_STEPS - 1)) state_in = ST_MAG;
         end
         ST_MAG: begin
            cnt_in   = '0;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(K_BITS - 1)) state_in = ST_ACC;
         end
         ST_ACC: state_in = ST_OUT;
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // datapath
   logic [GAIN_W:0] hm_sum;
   logic signed [CORDIC_W-1:0] qx_s, qy_s, xs, ys;
   logic signed [HEAD_W-1:0] neg_head, atan_v;
   logic [CORDIC_W:0] kx_sum, ky_sum;
   logic [HEAD_W-2:0] hq;
   logic signed [HEAD_W+1:0] h_next;
   logic signed [PW-1:0] dx_ext, dy_ext;

   always_comb begin
      hm_sum   = hm_acc_ff + (hm_low_ff[0] ? {1'b0, gain_ff} : '0);
      qx_s     = dx_neg_ff ? -CORDIC_W'(quot_x) : CORDIC_W'(quot_x);
      qy_s     = dy_neg_ff ? -CORDIC_W'(quot_y) : CORDIC_W'(quot_y);
      neg_head = -head_ff;
      xs       = cx_ff >>> cnt_ff;
      ys       = cy_ff >>> cnt_ff;
      atan_v   = atan_q22(cnt_ff);
      kx_sum   = {1'b0, kx_ff} + (CORDIC_K[cnt_ff] ? {1'b0, mx_ff} : '0);
      ky_sum   = {1'b0, ky_ff} + (CORDIC_K[cnt_ff] ? {1'b0, my_ff} : '0);
      hq       = {hm_acc_ff[GAIN_W-1:0], hm_low_ff[ABS_SUM_W-1:10]};
      h_next   = (HEAD_W+2)'(head_ff) +
                 (sum_pos_ff ? -(HEAD_W+2)'(hq) : (HEAD_W+2)'(hq));
      dx_ext   = kx_neg_ff ? -PW'(kx_ff) : PW'(kx_ff);
      dy_ext   = ky_neg_ff ? -PW'(ky_ff) : PW'(ky_ff);
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         dx_neg_ff  <= !along[ABS_SUM_W] && (along != '0);
         dy_neg_ff  <= diff[ABS_SUM_W-1];
         sum_pos_ff <= !sum[ABS_SUM_W-1] && (sum != '0);
         hm_acc_ff  <= '0;
         hm_low_ff  <= abs_sum;
      end else if (state_ff == ST_DIV && cnt_ff < CNT_W'(ABS_SUM_W)) begin
         hm_acc_ff <= {1'b0, hm_sum[GAIN_W:1]};
         hm_low_ff <= {hm_sum[0], hm_low_ff[ABS_SUM_W-1:1]};
      end
      case (state_ff)
         ST_PREP: begin
            if (neg_head > DEG_90) begin
               cx_ff  <= -qy_s;
               cy_ff  <= qx_s;
               ang_ff <= neg_head - DEG_90;
            end else if (neg_head < -DEG_90) begin
               cx_ff  <= qy_s;
               cy_ff  <= -qx_s;
               ang_ff <= neg_head + DEG_90;
            end else begin
               cx_ff  <= qx_s;
               cy_ff  <= qy_s;
               ang_ff <= neg_head;
            end
         end
         ST_ROT: begin
            if (!ang_ff[HEAD_W-1]) begin
               cx_ff  <= cx_ff - ys;
               cy_ff  <= cy_ff + xs;
               ang_ff <= ang_ff - atan_v;
            end else begin
               cx_ff  <= cx_ff + ys;
               cy_ff  <= cy_ff - xs;
               ang_ff <= ang_ff + atan_v;
            end
         end
         ST_MAG: begin
            kx_neg_ff <= cx_ff[CORDIC_W-1];
            ky_neg_ff <= cy_ff[CORDIC_W-1];
            mx_ff     <= cx_ff[CORDIC_W-1] ? CORDIC_W'(-cx_ff) : CORDIC_W'(cx_ff);
            my_ff     <= cy_ff[CORDIC_W-1] ? CORDIC_W'(-cy_ff) : CORDIC_W'(cy_ff);
            kx_ff     <= '0;
            ky_ff     <= '0;
         end
         ST_SCALE: begin
            kx_ff <= kx_sum[CORDIC_W:1];
            ky_ff <= ky_sum[CORDIC_W:1];
         end
         default: ;
      endcase
   end

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= GAIN_RESET;
         x_acc_ff <= '0;
         y_acc_ff <= '0;
         head_ff  <= '0;
      end else begin
         if (csr_valid) gain_ff <= csr_data;
         if (state_ff == ST_ACC) begin
            x_acc_ff <= x_acc_ff + dx_ext;
            y_acc_ff <= y_acc_ff + dy_ext;
            if (h_next > DEG_180)
               head_ff <= HEAD_W'(h_next - DEG_360);
            else if (h_next <= -DEG_180)
               head_ff <= HEAD_W'(h_next + DEG_360);
            else
               head_ff <= HEAD_W'(h_next);
         end
      end
   end

   // output formatting
   logic [PW-1:0] mag_x, mag_y;
   logic [PW-17:0] qx_o, qy_o;
   logic [HEAD_W-1:0] mag_h;
   logic [9:0] hd_mag;
   logic signed [15:0] ox, oy;
   logic signed [8:0] oh;

   always_comb begin
      mag_x  = x_acc_ff[PW-1] ? PW'(-x_acc_ff) : PW'(x_acc_ff);
      mag_y  = y_acc_ff[PW-1] ? PW'(-y_acc_ff) : PW'(y_acc_ff);
      qx_o   = mag_x[PW-1:16];
      qy_o   = mag_y[PW-1:16];
      if (x_acc_ff[PW-1])
         ox = (qx_o > (PW-16)'(32768)) ? -16'sd32768 : -$signed(qx_o[15:0]);
      else
         ox = (qx_o > (PW-16)'(32767)) ? 16'sd32767 : $signed(qx_o[15:0]);
      if (y_acc_ff[PW-1])
         oy = (qy_o > (PW-16)'(32768)) ? -16'sd32768 : -$signed(qy_o[15:0]);
      else
         oy = (qy_o > (PW-16)'(32767)) ? 16'sd32767 : $signed(qy_o[15:0]);
      mag_h  = head_ff[HEAD_W-1] ? HEAD_W'(-head_ff) : HEAD_W'(head_ff);
      hd_mag = mag_h[HEAD_W-1:HEAD_FRAC];
      oh     = head_ff[HEAD_W-1] ? -$signed(hd_mag[8:0]) : $signed(hd_mag[8:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_ready)) begin
         rsp_x_ff <= ox;
         rsp_y_ff <= oy;
         rsp_h_ff <= oh;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pos_x_mm    = rsp_x_ff;
   assign rsp_pos_y_mm    = rsp_y_ff;
   assign rsp_heading_deg = rsp_h_ff;

   a_head_range: assert property (@(posedge clock) disable iff (reset)
      (HEAD_W+2)'(head_ff) <= DEG_180 && (HEAD_W+2)'(head_ff) > -DEG_180)
      else $error("heading out of range");
   a_req_starts: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff == ST_DIV && cnt_ff == '0)
      else $error("request transfer did not start divide");
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && (!rsp_valid_ff || rsp_ready)) |=>
      rsp_valid_ff && state_ff == ST_IDLE)
      else $error("response not queued");
   a_acc_once: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ACC |=> state_ff == ST_OUT)
      else $error("accumulate step not followed by output");

endmodule
`default_nettype wire

FILE: test/tb_three_wheel_odometry_integrator.sv
// Testbench for three_wheel_odometry_integrator: directed and random wheel ticks,
// with an in-bench fixed-point odometry predictor and an in-order response check.
// Depends on twoi_pkg and the integrator RTL.
`timescale 1ns / 100ps
module tb_three_wheel_odometry_integrator;
   import twoi_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [SPEED_W-1:0] req_wheel_left_speed = '0;
   logic signed [SPEED_W-1:0] req_wheel_rear_speed = '0;
   logic signed [SPEED_W-1:0] req_wheel_right_speed = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_pos_x_mm;
   logic signed [15:0] rsp_pos_y_mm;
   logic signed [8:0] rsp_heading_deg;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [GAIN_W-1:0] csr_data = '0;

   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [8:0]  hd;
   } pose_type;

   pose_type pose_q[$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   // predictor state
   logic [GAIN_W-1:0] gain_r = GAIN_RESET;
   longint x_acc = 0;
   longint y_acc = 0;
   longint head_acc = 0;

   three_wheel_odometry_integrator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_wheel_left_speed(req_wheel_left_speed),
      .req_wheel_rear_speed(req_wheel_rear_speed),
      .req_wheel_right_speed(req_wheel_right_speed),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_pos_x_mm(rsp_pos_x_mm), .rsp_pos_y_mm(rsp_pos_y_mm),
      .rsp_heading_deg(rsp_heading_deg),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("three_wheel_odometry_integrator: mismatch");
      $finish;
   end

   function automatic longint arctan_q22(int i);
      longint t[24] = '{188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
                        3754631, 1877430, 938729, 469366, 234683, 117342,
                        58671, 29335, 14668, 7334, 3667, 1833,
                        917, 458, 229, 115, 57, 29};
      return t[i];
   endfunction

   function automatic longint k_scale(longint v);
      longint unsigned m;
      longint unsigned q;
      m = v < 0 ? -v : v;
      q = (m * 64'h9B74EDA8) >> 32;
      return v < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic signed [15:0] sat_mm(longint v);
      longint q;
      q = (v < 0 ? -v : v) >>> 16;
      if (v < 0) return q > 32768 ? -16'sd32768 : 16'(-q);
      return q > 32767 ? 16'sd32767 : 16'(q);
   endfunction

   function automatic longint wrap48(longint v);
      logic [47:0] w;
      w = v[47:0];
      return longint'($signed(w));
   endfunction

   function automatic pose_type integrate_tick(logic signed [15:0] l, logic signed [15:0] r,
                                               logic signed [15:0] rt);
      longint sum, x, y, ang, xs, ys, t, q;
      pose_type p;
      sum = longint'(l) + longint'(rt);
      x = (-(2 * longint'(r) + sum) * 4096) / 125;
      y = ((longint'(l) - longint'(rt)) * 4096) / 125;
      ang = -head_acc;
      if (ang > (longint'(90) << 22)) begin
         t = x; x = -y; y = t; ang -= longint'(90) << 22;
      end else if (ang < -(longint'(90) << 22)) begin
         t = x; x = y; y = -t; ang += longint'(90) << 22;
      end
      for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (ang >= 0) begin
            x -= ys; y += xs; ang -= arctan_q22(i);
         end else begin
            x += ys; y -= xs; ang += arctan_q22(i);
         end
      end
      x_acc = wrap48(x_acc + k_scale(x));
      y_acc = wrap48(y_acc + k_scale(y));
      q = ((sum < 0 ? -sum : sum) * longint'(gain_r)) >>> 10;
      head_acc += sum > 0 ? -q : q;
      if (head_acc > (longint'(180) << 22)) head_acc -= longint'(360) << 22;
      if (head_acc <= -(longint'(180) << 22)) head_acc += longint'(360) << 22;
      p.x = sat_mm(x_acc);
      p.y = sat_mm(y_acc);
      p.hd = head_acc < 0 ? 9'(-((-head_acc) >>> 22)) : 9'(head_acc >>> 22);
      return p;
   endfunction

   task automatic report_mismatch(string what, longint got, longint exp);
      $display("error at %0t: %s got %0d expected %0d", $realtime, what, got, exp);
      errors++;
   endtask

   always @(posedge clock) begin
      pose_type e;
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (pose_q.size() == 0) begin
            report_mismatch("unexpected transfer", 0, 0);
         end else begin
            e = pose_q.pop_front();
            if (rsp_pos_x_mm !== e.x) report_mismatch("pos_x_mm", rsp_pos_x_mm, e.x);
            if (rsp_pos_y_mm !== e.y) report_mismatch("pos_y_mm", rsp_pos_y_mm, e.y);
            if (rsp_heading_deg !== e.hd)
               report_mismatch("heading_deg", rsp_heading_deg, e.hd);
         end
      end
   end

   task automatic send_tick(logic signed [15:0] l, logic signed [15:0] r,
                            logic signed [15:0] rt);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_wheel_left_speed <= l;
      req_wheel_rear_speed <= r;
      req_wheel_right_speed <= rt;
      do @(posedge clock); while (!req_ready);
      pose_q.push_back(integrate_tick(l, r, rt));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pose_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_gain(logic [GAIN_W-1:0] v);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      gain_r = v;
   endtask

   task automatic test_directed();
      send_tick(0, 0, 0);
      send_tick(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_tick(-16'sh8000, -16'sh8000, -16'sh8000);
      send_tick(-16'sh8000, 0, 16'sh7FFF);
      send_tick(16'sh7FFF, 0, -16'sh8000);
      send_tick(1, -1, 1);
      send_tick(-1, 1, -1);
      drain();
      write_gain(24'hFFFFFF);
      // large turns to force heading wrap both ways and pre-rotation
      for (int i = 0; i < 6; i++) send_tick(16'sh7FFF, 0, 16'sh7FFF);
      for (int i = 0; i < 6; i++) send_tick(-16'sh8000, 100, -16'sh8000);
      send_tick(16'sh5555, -16'sh5556, -16'sh2AAB);
      drain();
      write_gain(0);
      send_tick(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      drain();
   endtask

   task automatic test_random(int n, int idle, int stall, logic [GAIN_W-1:0] g);
      int k;
      drain();
      write_gain(g);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(3);
         if (k == 0)
            send_tick(16'($urandom), 16'($urandom), 16'($urandom));
         else
            send_tick(16'($signed(10'($urandom))), 16'($signed(10'($urandom))),
                      16'($signed(10'($urandom))));
      end
      drain();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(107, 0, 0, GAIN_RESET);
      test_random(107, 50, 0, 24'hFFFFFF);
      test_random(107, 0, 50, 24'($urandom));
      test_random(107, 33, 33, 24'($urandom_range(1000)));
      if (errors == 0) begin
         $display("three_wheel_odometry_integrator: match");
      end else begin
         $display("three_wheel_odometry_integrator: mismatch");
      end
      $finish;
   end
endmodule

FILE: sim.f
sv/twoi_pkg.sv
sv/twoi_div125.sv
sv/three_wheel_odometry_integrator.sv
test/tb_three_wheel_odometry_integrator.sv
